### rtl/core/vertex_weld_and_face_remap_unit_defines.svh
// ---------------------------------------------------------------------------
// Vertex weld and face remap: assertion macros
// Shared concurrent assertion forms used by the block's top level.
// ---------------------------------------------------------------------------
`ifndef VERTEX_WELD_AND_FACE_REMAP_UNIT_DEFINES_SVH
`define VERTEX_WELD_AND_FACE_REMAP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define VWR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vertex weld assertion failed");

// Next-cycle implication, disabled during reset.
`define VWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vertex weld assertion failed");

`endif

### rtl/core/vwr_pkg.sv
// ---------------------------------------------------------------------------
// Vertex weld package
// Payload types and fixed constants shared by the weld and remap modules.
// ---------------------------------------------------------------------------
package vwr_pkg;

   localparam int COORD_W   = 32;
   localparam int KEY_W     = 64;
   localparam int FIELD_W   = 12;
   localparam int Q_SCALE   = 1000;
   localparam int Q_ROUND   = 32768;
   localparam int MIN_KEPT  = 3;

   typedef struct packed {
      logic                      req_type;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
      logic [FIELD_W-1:0]        corner_source;
      logic                      corner_last;
   } req_payload_type;

   typedef struct packed {
      logic [FIELD_W-1:0] vertex_index;
      logic               is_new_vertex;
      logic               table_full;
      logic               face_dropped;
      logic               face_too_long;
      logic               run_last;
   } rsp_payload_type;

   typedef struct packed {
      logic               is_corner;
      logic [COORD_W-1:0] qx;
      logic [COORD_W-1:0] qy;
      logic [COORD_W-1:0] qz;
      logic [FIELD_W-1:0] corner_source;
      logic               corner_last;
   } queue_entry_type;

endpackage

### rtl/core/vwr_stream_if.sv
// ---------------------------------------------------------------------------
// Vertex weld stream interface
// Valid/ready channel carrying one payload per transaction.
// ---------------------------------------------------------------------------
interface vwr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/core/vwr_ram.sv
// ---------------------------------------------------------------------------
// Vertex weld generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module vwr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

### rtl/core/vwr_front.sv
// ---------------------------------------------------------------------------
// Vertex weld front end
// Accepts transactions, quantises coordinates and queues them for the back.
// ---------------------------------------------------------------------------
module vwr_front (
   input  logic                     clock,
   input  logic                     reset,
   vwr_stream_if.sink               req_bus,
   input  logic                     accept_en,
   output vwr_pkg::queue_entry_type head,
   output logic                     head_valid,
   input  logic                     head_pop
);
   import vwr_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type       fifo_ff [DEPTH];
   queue_entry_type       entry;
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  push;

   function automatic logic [COORD_W-1:0] quantise(input logic signed [COORD_W-1:0] x);
      logic signed [47:0] v;
      v = 48'(x) * 48'sd1000 + 48'(Q_ROUND);
      return v[47:16];
   endfunction

   assign req_bus.ready = accept_en && (count_ff != CNT_W'(DEPTH));
   assign push          = req_bus.valid && req_bus.ready;
   assign head_valid    = (count_ff != '0);
   assign head          = fifo_ff[rd_ptr_ff];

   always_comb begin
      entry.is_corner     = req_bus.payload.req_type;
      entry.qx            = quantise(req_bus.payload.coord_x);
      entry.qy            = quantise(req_bus.payload.coord_y);
      entry.qz            = quantise(req_bus.payload.coord_z);
      entry.corner_source = req_bus.payload.corner_source;
      entry.corner_last   = req_bus.payload.corner_last;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = head_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(head_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         fifo_ff[wr_ptr_ff] <= entry;
      end
   end
endmodule

### rtl/core/vwr_back.sv
// ---------------------------------------------------------------------------
// Vertex weld back end
// Pairs keys, probes the slot table, records indices and remaps faces.
// ---------------------------------------------------------------------------
module vwr_back #(
   parameter int MAX_VERTICES     = 4096,
   parameter int HASH_SLOTS       = 4096,
   parameter int MAX_FACE_CORNERS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  vwr_pkg::queue_entry_type head,
   input  logic                     head_valid,
   output logic                     head_pop,
   output logic                     accept_en,
   vwr_stream_if.source             rsp_bus
);
   import vwr_pkg::*;

   localparam int IW     = $clog2(MAX_VERTICES);
   localparam int CW     = $clog2(MAX_VERTICES + 1);
   localparam int SW     = $clog2(HASH_SLOTS);
   localparam int FW     = $clog2(MAX_FACE_CORNERS);
   localparam int FCW    = $clog2(MAX_FACE_CORNERS + 1);
   localparam int SLOT_W = 1 + KEY_W + IW;
   localparam bit POW2   = (HASH_SLOTS & (HASH_SLOTS - 1)) == 0;
   localparam int DW     = 16;
   localparam int XW     = SW + DW;
   localparam logic [DW:0] RECIP = (DW+1)'((64'd1 << XW) / HASH_SLOTS);

   typedef enum logic [13:0] {
      ST_CLEAR    = 14'b00000000000001,
      ST_IDLE     = 14'b00000000000010,
      ST_SUM      = 14'b00000000000100,
      ST_MUL      = 14'b00000000001000,
      ST_FIN      = 14'b00000000010000,
      ST_MOD      = 14'b00000000100000,
      ST_PROBE_RD = 14'b00000001000000,
      ST_PROBE    = 14'b00000010000000,
      ST_VTX_OUT  = 14'b00000100000000,
      ST_PRV_RD   = 14'b00001000000000,
      ST_PRV      = 14'b00010000000000,
      ST_CRN_RD   = 14'b00100000000000,
      ST_CRN      = 14'b01000000000000,
      ST_FACE_OUT = 14'b10000000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [SW-1:0]        clr_ff, clr_in;
   queue_entry_type      entry_ff, entry_in;
   logic                 pass_ff, pass_in;
   logic [KEY_W-1:0]     opa_ff, opa_in, opb_ff, opb_in;
   logic [KEY_W-1:0]     sum_ff, sum_in, sum1_ff, sum1_in;
   logic [1:0]           step_ff, step_in;
   logic [KEY_W-1:0]     prod_ff, prod_in, acc_ff, acc_in, key_ff, key_in;
   logic [SW-1:0]        rem_ff, rem_in;
   logic [1:0]           dig_ff, dig_in;
   logic                 ph_ff, ph_in;
   logic [DW:0]          q_ff, q_in;
   logic [SW-1:0]        paddr_ff, paddr_in, pcnt_ff, pcnt_in;
   logic [CW-1:0]        uc_ff, uc_in, sc_ff, sc_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic                 nw_ff, nw_in, full_ff, full_in;
   logic [FIELD_W-1:0]   cbuf_ff [MAX_FACE_CORNERS];
   logic [FCW-1:0]       cc_ff, cc_in, j_ff, j_in, kept_ff, kept_in, k_ff, k_in;
   logic                 ovf_ff, ovf_in, unk_ff, unk_in;
   logic [IW-1:0]        prev_ff, prev_in;
   logic [IW-1:0]        keep_ff [MAX_FACE_CORNERS];
   logic                 out_valid_ff, out_valid_in;
   rsp_payload_type      out_ff, out_in;

   logic                 out_free, load;
   logic [31:0]          mul_a, mul_b;
   logic [KEY_W-1:0]     mul_full, res;
   logic [DW-1:0]        digit;
   logic [XW-1:0]        mod_x, mod_r;
   logic [XW+DW:0]       mod_prod, mod_qn;
   logic                 cbuf_wr, keep_wr;
   logic [FW-1:0]        cbuf_widx, cbuf_ridx;
   logic [FIELD_W-1:0]   cbuf_rd;
   logic                 slot_wr, slot_rd_en;
   logic [SW-1:0]        slot_waddr;
   logic [SLOT_W-1:0]    slot_wdata, slot_rdata;
   logic                 map_wr, map_rd_en;
   logic [IW-1:0]        map_rd_addr, map_rdata, mapped;

   vwr_ram #(.WIDTH(SLOT_W), .DEPTH(HASH_SLOTS)) u_slot_ram (
      .clock  (clock),
      .wr_en  (slot_wr),
      .wr_addr(slot_waddr),
      .wr_data(slot_wdata),
      .rd_en  (slot_rd_en),
      .rd_addr(paddr_ff),
      .rd_data(slot_rdata)
   );

   vwr_ram #(.WIDTH(IW), .DEPTH(MAX_VERTICES)) u_map_ram (
      .clock  (clock),
      .wr_en  (map_wr),
      .wr_addr(sc_ff[IW-1:0]),
      .wr_data(idx_ff),
      .rd_en  (map_rd_en),
      .rd_addr(map_rd_addr),
      .rd_data(map_rdata)
   );

   assign accept_en     = (state_ff != ST_CLEAR);
   assign head_pop      = (state_ff == ST_IDLE) && head_valid;
   assign out_free      = !out_valid_ff || rsp_bus.ready;
   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.payload = out_ff;
   assign mul_full      = {32'b0, mul_a} * {32'b0, mul_b};
   assign res           = {1'b0, acc_ff[KEY_W-1:1]} + opb_ff;
   assign mod_x         = {rem_ff, digit};
   assign mod_prod      = (XW+DW+1)'(mod_x) * (XW+DW+1)'(RECIP);
   assign mod_qn        = (XW+DW+1)'(q_ff) * (XW+DW+1)'(HASH_SLOTS);
   assign mod_r         = mod_x - mod_qn[XW-1:0];
   assign cbuf_ridx     = (state_ff == ST_PRV_RD) ? FW'(cc_ff - FCW'(1)) : FW'(j_ff);
   assign cbuf_rd       = cbuf_ff[cbuf_ridx];
   assign mapped        = unk_ff ? '0 : map_rdata;
   assign map_rd_addr   = IW'(cbuf_rd);

   always_comb begin
      case (step_ff)
         2'd0:    begin mul_a = sum_ff[31:0];  mul_b = sum1_ff[31:0];  end
         2'd1:    begin mul_a = sum_ff[63:32]; mul_b = sum1_ff[31:0];  end
         default: begin mul_a = sum_ff[31:0];  mul_b = sum1_ff[63:32]; end
      endcase
   end

   always_comb begin
      case (dig_ff)
         2'd0:    digit = key_ff[63:48];
         2'd1:    digit = key_ff[47:32];
         2'd2:    digit = key_ff[31:16];
         default: digit = key_ff[15:0];
      endcase
   end

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff; entry_in = entry_ff; pass_in = pass_ff;
      opa_in = opa_ff; opb_in = opb_ff; sum_in = sum_ff; sum1_in = sum1_ff;
      step_in = step_ff; prod_in = prod_ff; acc_in = acc_ff; key_in = key_ff;
      rem_in = rem_ff; dig_in = dig_ff; ph_in = ph_ff; q_in = q_ff;
      paddr_in = paddr_ff; pcnt_in = pcnt_ff;
      uc_in = uc_ff; sc_in = sc_ff; idx_in = idx_ff; nw_in = nw_ff; full_in = full_ff;
      cc_in = cc_ff; j_in = j_ff; kept_in = kept_ff; k_in = k_ff;
      ovf_in = ovf_ff; unk_in = unk_ff; prev_in = prev_ff;
      out_in = out_ff; load = 1'b0;
      cbuf_wr = 1'b0; cbuf_widx = FW'(cc_ff); keep_wr = 1'b0;
      slot_wr = 1'b0; slot_waddr = paddr_ff; slot_wdata = '0; slot_rd_en = 1'b0;
      map_wr = 1'b0; map_rd_en = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            slot_wr    = 1'b1;
            slot_waddr = clr_ff;
            clr_in     = clr_ff + SW'(1);
            if (clr_ff == SW'(HASH_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               entry_in = head;
               if (!head.is_corner) begin
                  opa_in   = {32'b0, head.qy};
                  opb_in   = {32'b0, head.qz};
                  pass_in  = 1'b0;
                  state_in = ST_SUM;
               end else begin
                  if (cc_ff < FCW'(MAX_FACE_CORNERS)) begin
                     cbuf_wr = 1'b1;
                     cc_in   = cc_ff + FCW'(1);
                  end else begin
                     ovf_in = 1'b1;
                  end
                  if (head.corner_last) begin
                     state_in = ST_PRV_RD;
                  end
               end
            end
         end
         ST_SUM: begin
            sum_in   = opa_ff + opb_ff;
            sum1_in  = opa_ff + opb_ff + KEY_W'(1);
            step_in  = 2'd0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in = mul_full;
            step_in = step_ff + 2'd1;
            case (step_ff)
               2'd0:    acc_in = acc_ff;
               2'd1:    acc_in = prod_ff;
               default: acc_in = acc_ff + {prod_ff[31:0], 32'b0};
            endcase
            if (step_ff == 2'd3) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!pass_ff) begin
               opa_in   = {32'b0, entry_ff.qx};
               opb_in   = res;
               pass_in  = 1'b1;
               state_in = ST_SUM;
            end else begin
               key_in   = res;
               rem_in   = '0;
               dig_in   = '0;
               ph_in    = 1'b0;
               pcnt_in  = '0;
               state_in = ST_MOD;
            end
         end
         ST_MOD: begin
            if (POW2) begin
               paddr_in = key_ff[SW-1:0];
               state_in = ST_PROBE_RD;
            end else begin
               if (!ph_ff) begin
                  q_in  = mod_prod[XW+DW:XW];
                  ph_in = 1'b1;
               end else begin
                  if (mod_r >= XW'(HASH_SLOTS)) begin
                     rem_in = SW'(mod_r - XW'(HASH_SLOTS));
                  end else begin
                     rem_in = mod_r[SW-1:0];
                  end
                  ph_in  = 1'b0;
                  dig_in = dig_ff + 2'd1;
                  if (dig_ff == 2'd3) begin
                     paddr_in = rem_in;
                     state_in = ST_PROBE_RD;
                  end
               end
            end
         end
         ST_PROBE_RD: begin
            slot_rd_en = 1'b1;
            state_in   = ST_PROBE;
         end
         ST_PROBE: begin
            state_in = ST_VTX_OUT;
            nw_in    = 1'b0;
            full_in  = 1'b0;
            idx_in   = '0;
            if (!slot_rdata[SLOT_W-1]) begin
               if (uc_ff < CW'(MAX_VERTICES)) begin
                  slot_wr    = 1'b1;
                  slot_wdata = {1'b1, key_ff, IW'(uc_ff)};
                  idx_in     = IW'(uc_ff);
                  uc_in      = uc_ff + CW'(1);
                  nw_in      = 1'b1;
               end else begin
                  full_in = 1'b1;
               end
            end else if (slot_rdata[SLOT_W-2 -: KEY_W] == key_ff) begin
               idx_in = slot_rdata[IW-1:0];
            end else if (pcnt_ff == SW'(HASH_SLOTS - 1)) begin
               full_in = 1'b1;
            end else begin
               pcnt_in  = pcnt_ff + SW'(1);
               paddr_in = (paddr_ff == SW'(HASH_SLOTS - 1)) ? '0 : paddr_ff + SW'(1);
               state_in = ST_PROBE_RD;
            end
         end
         ST_VTX_OUT: begin
            if (out_free) begin
               load                = 1'b1;
               out_in.vertex_index = FIELD_W'(idx_ff);
               out_in.is_new_vertex = nw_ff;
               out_in.table_full   = full_ff;
               out_in.face_dropped = 1'b0;
               out_in.face_too_long = 1'b0;
               out_in.run_last     = 1'b1;
               if (sc_ff < CW'(MAX_VERTICES)) begin
                  map_wr = 1'b1;
                  sc_in  = sc_ff + CW'(1);
               end
               state_in = ST_IDLE;
            end
         end
         ST_PRV_RD: begin
            map_rd_en = 1'b1;
            unk_in    = 32'(cbuf_rd) >= 32'(sc_ff);
            state_in  = ST_PRV;
         end
         ST_PRV: begin
            prev_in  = mapped;
            j_in     = '0;
            kept_in  = '0;
            state_in = ST_CRN_RD;
         end
         ST_CRN_RD: begin
            map_rd_en = 1'b1;
            unk_in    = 32'(cbuf_rd) >= 32'(sc_ff);
            state_in  = ST_CRN;
         end
         ST_CRN: begin
            if (mapped != prev_ff) begin
               keep_wr = 1'b1;
               kept_in = kept_ff + FCW'(1);
            end
            prev_in = mapped;
            j_in    = j_ff + FCW'(1);
            if (j_in == cc_ff) begin
               k_in     = '0;
               state_in = ST_FACE_OUT;
            end else begin
               state_in = ST_CRN_RD;
            end
         end
         ST_FACE_OUT: begin
            if (out_free) begin
               load                 = 1'b1;
               out_in.is_new_vertex = 1'b0;
               out_in.table_full    = 1'b0;
               out_in.face_too_long = ovf_ff;
               if (kept_ff < FCW'(MIN_KEPT)) begin
                  out_in.vertex_index = '0;
                  out_in.face_dropped = 1'b1;
                  out_in.run_last     = 1'b1;
               end else begin
                  out_in.vertex_index = FIELD_W'(keep_ff[FW'(k_ff)]);
                  out_in.face_dropped = 1'b0;
                  out_in.run_last     = (k_ff + FCW'(1) == kept_ff);
               end
               k_in = k_ff + FCW'(1);
               if (out_in.run_last) begin
                  cc_in    = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      out_valid_in = load ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         uc_ff        <= '0;
         sc_ff        <= '0;
         cc_ff        <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         uc_ff        <= uc_in;
         sc_ff        <= sc_in;
         cc_ff        <= cc_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
      entry_ff <= entry_in; pass_ff <= pass_in;
      opa_ff <= opa_in; opb_ff <= opb_in; sum_ff <= sum_in; sum1_ff <= sum1_in;
      step_ff <= step_in; prod_ff <= prod_in; acc_ff <= acc_in; key_ff <= key_in;
      rem_ff <= rem_in; dig_ff <= dig_in; ph_ff <= ph_in; q_ff <= q_in;
      paddr_ff <= paddr_in; pcnt_ff <= pcnt_in;
      idx_ff <= idx_in; nw_ff <= nw_in; full_ff <= full_in;
      j_ff <= j_in; kept_ff <= kept_in; k_ff <= k_in;
      unk_ff <= unk_in; prev_ff <= prev_in; out_ff <= out_in;
      if (cbuf_wr) begin
         cbuf_ff[cbuf_widx] <= head.corner_source;
      end
      if (keep_wr) begin
         keep_ff[FW'(kept_ff)] <= mapped;
      end
   end
endmodule

### rtl/core/vertex_weld_and_face_remap_unit.sv
// ---------------------------------------------------------------------------
// Vertex weld and face remap unit
// Welds coincident vertices by quantised key and remaps face corners.
// ---------------------------------------------------------------------------
// After reset the slot table is swept clear slot by slot, during which no
// transaction is accepted. The back end then pairs a vertex into a key,
// reduces it digit-wise modulo HASH_SLOTS when HASH_SLOTS is not a power of
// two, and probes for it; the key pairing runs through one shared 32-bit
// multiplier and each probe is one slot RAM read. A face corner without
// the last flag is buffered, or flags an overflow when the buffer is full;
// the closing corner makes one index map read for the last buffered corner
// and one for each buffered corner, then emits its results. A two-entry
// queue decouples input acceptance from this work, and the output register
// holds each result until taken, stalling the back end while it is full.
`include "vertex_weld_and_face_remap_unit_defines.svh"

module vertex_weld_and_face_remap_unit #(
   parameter int MAX_VERTICES     = 4096,
   parameter int HASH_SLOTS       = 4096,
   parameter int MAX_FACE_CORNERS = 16
) (
   input  logic         clock,
   input  logic         reset,
   vwr_stream_if.sink   req_bus,
   vwr_stream_if.source rsp_bus
);
   import vwr_pkg::*;

   queue_entry_type head;
   logic            head_valid;
   logic            head_pop;
   logic            accept_en;

   vwr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .accept_en (accept_en),
      .head      (head),
      .head_valid(head_valid),
      .head_pop  (head_pop)
   );

   vwr_back #(
      .MAX_VERTICES    (MAX_VERTICES),
      .HASH_SLOTS      (HASH_SLOTS),
      .MAX_FACE_CORNERS(MAX_FACE_CORNERS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .head_valid(head_valid),
      .head_pop  (head_pop),
      .accept_en (accept_en),
      .rsp_bus   (rsp_bus)
   );

   `VWR_ASSERT_NOW(a_no_accept_clear, clock, reset, !accept_en, !req_bus.ready)
   `VWR_ASSERT_NOW(a_new_not_full, clock, reset,
      rsp_bus.valid && rsp_bus.payload.is_new_vertex,
      !rsp_bus.payload.table_full && !rsp_bus.payload.face_dropped)
   `VWR_ASSERT_NOW(a_drop_single, clock, reset,
      rsp_bus.valid && rsp_bus.payload.face_dropped,
      rsp_bus.payload.run_last && (rsp_bus.payload.vertex_index == '0))
   `VWR_ASSERT_NEXT(a_pop_has_item, clock, reset, head_pop, accept_en)
endmodule
